// ===== design/nsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nsl_pkg;

  localparam int ADDR_W      = 32;
  localparam int ENTRY_IDX_W = 10;
  localparam int COUNT_W     = 11;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int MAX_SYMBOLS_DEFAULT = 1024;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t DIST_INIT = ~addr_t'(0);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_LOAD_DELTA   = 2'd0;
  localparam logic [1:0] REG_SIZE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd2;

  typedef struct packed {
    addr_t start;
    addr_t length;
    addr_t name;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== design/nsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/nearest_symbol_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A load request writes one table entry if its index lies in the table; busy stays low.
// A query walks entries 0 to count-1, count cut to the table depth, one entry per cycle
// through the single table read port, and strobes done when the walk is through, sooner
// when an exact match ends the walk or the last entry is skipped.
// One request is handled at a time, and the result is strobed for one cycle only.
// Reset clears control, config and result registers; the table is unknown until loaded.
module nearest_symbol_lookup #(
  parameter int MAX_SYMBOLS = nsl_pkg::MAX_SYMBOLS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            op,
  input  wire logic [nsl_pkg::ENTRY_IDX_W-1:0] entry_index,
  input  wire logic [nsl_pkg::ADDR_W-1:0]      entry_start,
  input  wire logic [nsl_pkg::ADDR_W-1:0]      entry_length,
  input  wire logic [nsl_pkg::ADDR_W-1:0]      entry_name_offset,
  input  wire logic [nsl_pkg::ADDR_W-1:0]      query_address,
  output logic                                 done,
  output logic                                 found,
  output logic                                 exact_match,
  output logic      [nsl_pkg::ADDR_W-1:0]      base_address,
  output logic      [nsl_pkg::ADDR_W-1:0]      name_offset,
  output logic      [nsl_pkg::ENTRY_IDX_W-1:0] symbol_index,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nsl_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [nsl_pkg::PDATA_W-1:0]     pwdata,
  output logic      [nsl_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);

  import nsl_pkg::*;

  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  addr_t              load_delta;
  addr_t              size_limit;
  logic [COUNT_W-1:0] symbol_count;

  logic [1:0] reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_delta   <= '0;
      size_limit   <= '0;
      symbol_count <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_LOAD_DELTA:   load_delta   <= pwdata;
        REG_SIZE_LIMIT:   size_limit   <= pwdata;
        REG_SYMBOL_COUNT: symbol_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LOAD_DELTA:   prdata = load_delta;
      REG_SIZE_LIMIT:   prdata = size_limit;
      REG_SYMBOL_COUNT: prdata = PDATA_W'(symbol_count);
      default:          prdata = '0;
    endcase
  end

  logic       accept;
  logic       load_we;
  logic [31:0] count_sat;
  entry_t     wr_entry;
  entry_t     rd_entry;

  logic [CNT_W-1:0] issue_idx;
  logic [CNT_W-1:0] scan_count;
  logic             issuing;

  assign busy    = (state == S_SCAN);
  assign accept  = start && !busy;
  assign load_we = accept && (op == OP_LOAD) && (32'(entry_index) < 32'(MAX_SYMBOLS));
  assign wr_entry = '{start: entry_start, length: entry_length, name: entry_name_offset};
  assign count_sat = (32'(symbol_count) > 32'(MAX_SYMBOLS)) ? 32'(MAX_SYMBOLS)
                                                            : 32'(symbol_count);
  assign issuing = (state == S_SCAN) && (issue_idx != scan_count);

  nsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(entry_index)),
    .wdata (wr_entry),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  logic             q_valid;
  logic [IDX_W-1:0] q_idx;

  logic             a_valid;
  addr_t            a_base;
  addr_t            a_length;
  addr_t            a_name;
  logic [IDX_W-1:0] a_idx;

  logic  usable;
  addr_t rel_base;
  assign usable   = (rd_entry.start != '0) && (rd_entry.length < size_limit);
  assign rel_base = rd_entry.start + load_delta;

  addr_t query_addr;
  addr_t best_dist;
  addr_t distance;
  logic  above;
  logic  hit;
  logic  nearer;
  logic  finish;

  assign above    = a_base > query_addr;
  assign distance = query_addr - a_base;
  assign hit      = a_valid && !above && (distance < a_length);
  assign nearer   = a_valid && !above && (distance < best_dist);
  assign finish   = hit || (!issuing && !q_valid && !a_valid);

  logic [IDX_W-1:0] best_idx;
  assign symbol_index = ENTRY_IDX_W'(best_idx);

  always_ff @(posedge clk) begin
    a_base   <= rel_base;
    a_length <= rd_entry.length;
    a_name   <= rd_entry.name;
    a_idx    <= q_idx;
    q_idx    <= issue_idx[IDX_W-1:0];
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      q_valid      <= 1'b0;
      a_valid      <= 1'b0;
      issue_idx    <= '0;
      scan_count   <= '0;
      query_addr   <= '0;
      best_dist    <= DIST_INIT;
      found        <= 1'b0;
      exact_match  <= 1'b0;
      base_address <= '0;
      name_offset  <= '0;
      best_idx     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          q_valid <= 1'b0;
          a_valid <= 1'b0;
          if (accept && (op == OP_QUERY)) begin
            state        <= S_SCAN;
            issue_idx    <= '0;
            scan_count   <= CNT_W'(count_sat);
            query_addr   <= query_address;
            best_dist    <= DIST_INIT;
            found        <= 1'b0;
            exact_match  <= 1'b0;
            base_address <= '0;
            name_offset  <= '0;
            best_idx     <= '0;
          end
        end
        S_SCAN: begin
          q_valid <= issuing;
          a_valid <= q_valid && usable;
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (hit || nearer) begin
            found        <= 1'b1;
            base_address <= a_base;
            name_offset  <= a_name;
            best_idx     <= a_idx;
            best_dist    <= distance;
          end
          if (hit) begin
            exact_match <= 1'b1;
          end
          if (finish) begin
            state   <= S_IDLE;
            done    <= 1'b1;
            q_valid <= 1'b0;
            a_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/nearest_symbol_lookup_test.sv =====
`timescale 1ns / 1ps

module nearest_symbol_lookup_test;
  import nsl_pkg::*;

  localparam int TABLE_DEPTH = MAX_SYMBOLS_DEFAULT;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                   op;
    logic [ENTRY_IDX_W-1:0] slot;
    addr_t                  start_value;
    addr_t                  size_bytes;
    addr_t                  name_off;
    addr_t                  addr;
  } lookup_req_t;

  typedef struct packed {
    logic                   found;
    logic                   exact;
    addr_t                  base;
    addr_t                  name_off;
    logic [ENTRY_IDX_W-1:0] slot;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = OP_LOAD;
  logic [ENTRY_IDX_W-1:0] entry_index = '0;
  logic [ADDR_W-1:0] entry_start = '0;
  logic [ADDR_W-1:0] entry_length = '0;
  logic [ADDR_W-1:0] entry_name_offset = '0;
  logic [ADDR_W-1:0] query_address = '0;
  logic done;
  logic found;
  logic exact_match;
  logic [ADDR_W-1:0] base_address;
  logic [ADDR_W-1:0] name_offset;
  logic [ENTRY_IDX_W-1:0] symbol_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  nearest_symbol_lookup uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .entry_index(entry_index),
    .entry_start(entry_start),
    .entry_length(entry_length),
    .entry_name_offset(entry_name_offset),
    .query_address(query_address),
    .done(done),
    .found(found),
    .exact_match(exact_match),
    .base_address(base_address),
    .name_offset(name_offset),
    .symbol_index(symbol_index),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Mirror of the table and registers as the block should hold them.
  addr_t sym_start [TABLE_DEPTH];
  addr_t sym_length [TABLE_DEPTH];
  addr_t sym_name [TABLE_DEPTH];
  addr_t cfg_delta = '0;
  addr_t cfg_limit = '0;
  logic [COUNT_W-1:0] cfg_count = '0;

  // Table contents as planned by the stimulus, ahead of the block.
  bit [31:0] plan_start [TABLE_DEPTH];
  bit [31:0] plan_length [TABLE_DEPTH];
  bit plan_loaded [TABLE_DEPTH];
  bit [31:0] cluster_base = '0;

  lookup_req_t pending_reqs[$];
  lookup_result_t expected_results[$];
  lookup_req_t in_flight;
  lookup_result_t head_result;
  int unsigned gap_left = 0;
  int unsigned items_queued = 0;
  int unsigned mismatch_count = 0;
  bit steady_flow = 1'b0;

  function automatic int unsigned active_count();
    return (32'(cfg_count) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(cfg_count);
  endfunction

  function automatic lookup_result_t resolve_address(addr_t addr);
    lookup_result_t res;
    addr_t nearest;
    addr_t base;
    addr_t distance;
    res = '0;
    nearest = DIST_INIT;
    for (int unsigned i = 0; i < active_count() && !res.exact; i++) begin
      base = sym_start[i] + cfg_delta;
      if (sym_start[i] != '0 && sym_length[i] < cfg_limit && base <= addr) begin
        distance = addr - base;
        if (distance < sym_length[i] || distance < nearest) begin
          res.found = 1'b1;
          res.exact = distance < sym_length[i];
          res.base = base;
          res.name_off = sym_name[i];
          res.slot = ENTRY_IDX_W'(i);
          nearest = distance;
        end
      end
    end
    return res;
  endfunction

  function automatic void apply_request(lookup_req_t req);
    if (req.op == OP_LOAD) begin
      sym_start[req.slot] = req.start_value;
      sym_length[req.slot] = req.size_bytes;
      sym_name[req.slot] = req.name_off;
    end else begin
      expected_results.push_back(resolve_address(req.addr));
    end
  endfunction

  function automatic int unsigned choose_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (steady_flow || roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void queue_load(int unsigned slot, addr_t st, addr_t len, addr_t nm);
    lookup_req_t req;
    req.op = OP_LOAD;
    req.slot = ENTRY_IDX_W'(slot);
    req.start_value = st;
    req.size_bytes = len;
    req.name_off = nm;
    req.addr = $urandom;
    pending_reqs.push_back(req);
    plan_start[slot] = st;
    plan_length[slot] = len;
    plan_loaded[slot] = 1'b1;
    items_queued++;
  endfunction

  function automatic void queue_query(addr_t addr);
    lookup_req_t req;
    req.op = OP_QUERY;
    req.slot = ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    req.start_value = $urandom;
    req.size_bytes = $urandom;
    req.name_off = $urandom;
    req.addr = addr;
    pending_reqs.push_back(req);
    items_queued++;
  endfunction

  function automatic void queue_random_load(int unsigned slot);
    addr_t st;
    addr_t len;
    case ($urandom_range(0, 15))
      0: st = '0;
      1: st = $urandom;
      2, 3: st = plan_start[$urandom_range(0, TABLE_DEPTH - 1)];
      default: st = cluster_base + $urandom_range(0, 8191);
    endcase
    case ($urandom_range(0, 15))
      0: len = '0;
      1: len = $urandom;
      2: len = cfg_limit;
      3: len = cfg_limit - 1;
      default: len = $urandom_range(1, 512);
    endcase
    queue_load(slot, st, len, $urandom);
  endfunction

  function automatic void queue_random_query();
    int unsigned n;
    int unsigned k;
    addr_t base;
    n = active_count();
    k = (n == 0) ? 0 : $urandom_range(0, n - 1);
    base = plan_start[k] + cfg_delta;
    case ($urandom_range(0, 7))
      0: queue_query($urandom);
      1: queue_query(cluster_base + cfg_delta + $urandom_range(0, 16383));
      2: queue_query(base + plan_length[k] - $urandom_range(0, 1));
      3: queue_query(base - $urandom_range(0, 1));
      default: queue_query(base + $urandom_range(0, 700));
    endcase
  endfunction

  // Every slot below the searched count is loaded before any query, so no
  // request reads an entry that was never written.
  function automatic void load_missing_slots();
    for (int unsigned i = 0; i < active_count(); i++) begin
      if (!plan_loaded[i]) queue_random_load(i);
    end
  endfunction

  task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_index)
      REG_LOAD_DELTA: cfg_delta = value;
      REG_SIZE_LIMIT: cfg_limit = value;
      REG_SYMBOL_COUNT: cfg_count = value[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle(input int unsigned extra);
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) apply_request(in_flight);
      if (start && busy) begin
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        in_flight = pending_reqs.pop_front();
        op <= in_flight.op;
        entry_index <= in_flight.slot;
        entry_start <= in_flight.start_value;
        entry_length <= in_flight.size_bytes;
        entry_name_offset <= in_flight.name_off;
        query_address <= in_flight.addr;
        start <= 1'b1;
        gap_left <= choose_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: base_address 0x%0h", base_address);
        mismatch_count++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("found", 32'(head_result.found), 32'(found));
        check_field("exact_match", 32'(head_result.exact), 32'(exact_match));
        check_field("base_address", head_result.base, base_address);
        check_field("name_offset", head_result.name_off, name_offset);
        check_field("symbol_index", 32'(head_result.slot), 32'(symbol_index));
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_register(REG_LOAD_DELTA, '0);
    write_register(REG_SIZE_LIMIT, '1);
    write_register(REG_SYMBOL_COUNT, 4);
    queue_load(0, 32'h1000, 32'h10, 32'hFFFF_FFFF);
    queue_load(1, 32'h0, 32'h100, 32'h1111_1111);
    queue_load(2, 32'h1000, 32'h20, 32'h2222_2222);
    queue_load(3, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    queue_load(TABLE_DEPTH - 1, '1, '1, '1);
    queue_query(32'h1008);
    queue_query(32'h1018);
    queue_query(32'h2000);
    queue_query(32'h0);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'hFFF);
    settle(8);

    // A start of one relocated to zero is the furthest an entry can lie below.
    write_register(REG_LOAD_DELTA, '1);
    write_register(REG_SYMBOL_COUNT, 1);
    queue_load(0, 32'h1, 32'h5, 32'hABCD_0123);
    queue_query(32'hFFFF_FFFF);
    queue_query(32'hFFFF_FFFE);
    queue_query(32'h3);
    queue_query(32'h0);
    settle(8);

    write_register(REG_SIZE_LIMIT, 5);
    queue_query(32'h2);
    settle(8);
    write_register(REG_SIZE_LIMIT, 0);
    queue_query(32'h2);
    settle(8);
    write_register(REG_SIZE_LIMIT, 6);
    write_register(REG_UNUSED, 0);
    queue_query(32'h2);
    settle(8);
    write_register(REG_SYMBOL_COUNT, 0);
    queue_query(32'h2);
    settle(8);

    cluster_base = $urandom;
    while (items_queued < 580) begin
      case ($urandom_range(0, 5))
        0: write_register(REG_LOAD_DELTA, '0);
        1: write_register(REG_LOAD_DELTA, '1);
        2: write_register(REG_LOAD_DELTA, $urandom);
        default: write_register(REG_LOAD_DELTA, $urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0: write_register(REG_SIZE_LIMIT, '0);
        1: write_register(REG_SIZE_LIMIT, '1);
        2: write_register(REG_SIZE_LIMIT, $urandom_range(1, 64));
        3: write_register(REG_SIZE_LIMIT, $urandom);
        default: write_register(REG_SIZE_LIMIT, $urandom_range(256, 1024));
      endcase
      case ($urandom_range(0, 9))
        0: write_register(REG_SYMBOL_COUNT, 0);
        1: write_register(REG_SYMBOL_COUNT, $urandom_range(33, 300));
        default: write_register(REG_SYMBOL_COUNT, $urandom_range(1, 32));
      endcase
      if ($urandom_range(0, 2) == 0) cluster_base = $urandom;
      steady_flow = ($urandom_range(0, 3) == 0);
      load_missing_slots();
      n = active_count();
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 9) < 3) begin
          if (n == 0 || $urandom_range(0, 2) == 0)
            queue_random_load($urandom_range(0, TABLE_DEPTH - 1));
          else
            queue_random_load($urandom_range(0, n - 1));
        end else begin
          queue_random_query();
        end
      end
      settle(8);
    end

    // A count at or beyond the table depth is cut to the depth. Each query here
    // ends on an exact match in the first slot, so the walk stops before any
    // slot that was never loaded.
    steady_flow = 1'b0;
    write_register(REG_SIZE_LIMIT, '1);
    write_register(REG_LOAD_DELTA, $urandom);
    write_register(REG_SYMBOL_COUNT, 1);
    queue_load(0, 32'h0000_4000, 32'h40, $urandom);
    settle(8);
    write_register(REG_SYMBOL_COUNT, 32'({COUNT_W{1'b1}}));
    repeat (6) queue_query(32'h0000_4000 + cfg_delta + $urandom_range(0, 63));
    settle(8);
    write_register(REG_SYMBOL_COUNT, TABLE_DEPTH);
    repeat (6) queue_query(32'h0000_4000 + cfg_delta + $urandom_range(0, 63));
    settle(8);

    if (mismatch_count == 0) begin
      $display("nearest_symbol_lookup_test: done, clean");
    end else begin
      $display("nearest_symbol_lookup_test: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("nearest_symbol_lookup_test: done, errors");
    $finish;
  end

endmodule
